>>> design/detector_pixel_to_unit_q_macros.svh
// assertion macros used by the checker file
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef DETECTOR_PIXEL_TO_UNIT_Q_MACROS_SVH
`define DETECTOR_PIXEL_TO_UNIT_Q_MACROS_SVH

// property checked outside reset
`define DPTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every edge, reset included
`define DPTU_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> design/dptu_pkg.sv
// shared constants and types of the pixel to unit vector pipeline
// no dependencies
package dptu_pkg;

  // fraction bits of the final and of the intermediate unit vector
  localparam int OUT_FRAC_BITS = 30;
  localparam int MID_FRAC      = 30;

  // datapath widths
  localparam int VEC_W    = 57;
  localparam int LEAD_W   = 6;
  localparam int MAG_W    = 30;
  localparam int NORM_MSB = 29;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = 62;
  localparam int ROOT_W   = 31;
  localparam int REM_W    = 32;
  localparam int QUO_W    = 31;
  localparam int NUM_W    = 61;
  localparam int FB_W     = 5;
  localparam int COEF_W   = 21;
  localparam int Q_W      = 32;
  localparam int Q_LIMIT  = 1 << OUT_FRAC_BITS;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_X_AXIS   = 3'd0,
    CFG_Y_AXIS   = 3'd1,
    CFG_TRANS_XY = 3'd2,
    CFG_TRANS_Z  = 3'd3,
    CFG_ROT_ROW0 = 3'd4,
    CFG_ROT_ROW1 = 3'd5,
    CFG_ROT_ROW2 = 3'd6
  } cfg_idx_e;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [Q_W-1:0]   res_t;

  // control that travels with a vector through a normalizer
  typedef struct packed {
    logic valid;
    logic ok;
  } unit_ctl_t;

endpackage

>>> design/dptu_unit.sv
// pipelined vector normalizer: block scaling, square root, three dividers
// depends on dptu_pkg
module dptu_unit import dptu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [FB_W-1:0] fb_i,
  input  unit_ctl_t       ctl_i,
  input  vec_t            vec_i [3],
  output unit_ctl_t       ctl_o,
  output res_t            res_o [3]
);

  typedef struct packed {
    logic                   ok;
    logic [2:0]             neg;
    logic [2:0][MAG_W-1:0]  m;
  } side_t;

  // stage 1: magnitudes, signs, or of all magnitudes
  logic [VEC_W-1:0] mag1_d [3];
  logic [VEC_W-1:0] m1_q [3];
  logic [VEC_W-1:0] or1_q;
  logic [2:0]       neg1_q;
  logic             ok1_q, v1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1_d[i] = vec_i[i][VEC_W-1] ? VEC_W'(-vec_i[i]) : vec_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m1_q[i]   <= mag1_d[i];
        neg1_q[i] <= vec_i[i][VEC_W-1];
      end
      or1_q <= mag1_d[0] | mag1_d[1] | mag1_d[2];
      ok1_q <= ctl_i.ok && (|(mag1_d[0] | mag1_d[1] | mag1_d[2]));
    end
  end

  // stage 2: leading one of the largest magnitude
  logic [LEAD_W-1:0] lead2_d, lead2_q;
  logic [VEC_W-1:0]  m2_q [3];
  logic [2:0]        neg2_q;
  logic              ok2_q, v2_q;

  always_comb begin
    lead2_d = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (or1_q[i]) lead2_d = LEAD_W'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lead2_q <= lead2_d;
      m2_q    <= m1_q;
      neg2_q  <= neg1_q;
      ok2_q   <= ok1_q;
    end
  end

  // stage 3: common shift that puts the leading one at bit 29
  logic [VEC_W-1:0] sh3_d [3];
  side_t            s3_q;
  logic             v3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead2_q >= LEAD_W'(NORM_MSB)) begin
        sh3_d[i] = m2_q[i] >> (lead2_q - LEAD_W'(NORM_MSB));
      end else begin
        sh3_d[i] = m2_q[i] << (LEAD_W'(NORM_MSB) - lead2_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s3_q.m[i] <= sh3_d[i][MAG_W-1:0];
      end
      s3_q.neg <= neg2_q;
      s3_q.ok  <= ok2_q;
    end
  end

  // stage 4: squares
  logic [SQ_W-1:0] sq4_q [3];
  side_t           s4_q;
  logic            v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= SQ_W'(s3_q.m[i]) * SQ_W'(s3_q.m[i]);
      end
      s4_q <= s3_q;
    end
  end

  // square root pipeline, one result bit per stage; index 0 holds the sum
  logic [SUM_W-1:0]  rt_s_q    [ROOT_W+1];
  logic [REM_W-1:0]  rt_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] rt_root_q [ROOT_W+1];
  side_t             rt_side_q [ROOT_W+1];
  logic              rt_v_q    [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_v_q[0] <= 1'b0;
    end else if (en_i) begin
      rt_v_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_s_q[0]    <= SUM_W'(sq4_q[0]) + SUM_W'(sq4_q[1]) + SUM_W'(sq4_q[2]);
      rt_rem_q[0]  <= '0;
      rt_root_q[0] <= '0;
      rt_side_q[0] <= s4_q;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W+1:0]  rsh, trial;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    always_comb begin
      rsh   = {rt_rem_q[k], rt_s_q[k][SUM_W-1-2*k -: 2]};
      trial = {1'b0, rt_root_q[k], 2'b01};
      if (rsh >= trial) begin
        rem_d  = REM_W'(rsh - trial);
        root_d = {rt_root_q[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rsh[REM_W-1:0];
        root_d = {rt_root_q[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        rt_v_q[k+1] <= rt_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_s_q[k+1]    <= rt_s_q[k];
        rt_rem_q[k+1]  <= rem_d;
        rt_root_q[k+1] <= root_d;
        rt_side_q[k+1] <= rt_side_q[k];
      end
    end
  end

  // dividend setup: magnitude scaled by 2^fb plus half the length for rounding
  logic [NUM_W-1:0]  num_d [3];
  logic [QUO_W-1:0]  dv_rem_q  [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_low_q  [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_quo_q  [QUO_W+1][3];
  logic [ROOT_W-1:0] dv_len_q  [QUO_W+1];
  logic [2:0]        dv_neg_q  [QUO_W+1];
  logic              dv_ok_q   [QUO_W+1];
  logic              dv_v_q    [QUO_W+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NUM_W'(rt_side_q[ROOT_W].m[i]) << fb_i)
               + NUM_W'(rt_root_q[ROOT_W] >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_v_q[0] <= rt_v_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= QUO_W'(num_d[i][NUM_W-1:QUO_W]);
        dv_low_q[0][i] <= num_d[i][QUO_W-1:0];
        dv_quo_q[0][i] <= '0;
      end
      dv_len_q[0] <= rt_root_q[ROOT_W];
      dv_neg_q[0] <= rt_side_q[ROOT_W].neg;
      dv_ok_q[0]  <= rt_side_q[ROOT_W].ok;
    end
  end

  // restoring division, one quotient bit per stage for all three lanes
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [QUO_W:0]   rsh [3];
    logic [QUO_W-1:0] rem_d [3];
    logic [QUO_W-1:0] quo_d [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rsh[i] = {dv_rem_q[k][i], dv_low_q[k][i][QUO_W-1-k]};
        if (rsh[i] >= {1'b0, dv_len_q[k]}) begin
          rem_d[i] = QUO_W'(rsh[i] - {1'b0, dv_len_q[k]});
          quo_d[i] = {dv_quo_q[k][i][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[i] = rsh[i][QUO_W-1:0];
          quo_d[i] = {dv_quo_q[k][i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[k+1] <= rem_d;
        dv_low_q[k+1] <= dv_low_q[k];
        dv_quo_q[k+1] <= quo_d;
        dv_len_q[k+1] <= dv_len_q[k];
        dv_neg_q[k+1] <= dv_neg_q[k];
        dv_ok_q[k+1]  <= dv_ok_q[k];
      end
    end
  end

  // output stage: restore signs
  res_t res_q [3];
  logic out_v_q, out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= dv_v_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        res_q[i] <= dv_neg_q[QUO_W][i] ? -res_t'(dv_quo_q[QUO_W][i])
                                       :  res_t'(dv_quo_q[QUO_W][i]);
      end
      out_ok_q <= dv_ok_q[QUO_W];
    end
  end

  assign ctl_o.valid = out_v_q;
  assign ctl_o.ok    = out_ok_q;
  assign res_o       = res_q;

endmodule

>>> design/detector_pixel_to_unit_q.sv
// top level: pixel position to unit scattering vector
// depends on dptu_pkg and dptu_unit
//
// Usage
//   Input channel: in_valid_i with pixel_x_i, pixel_y_i, source_depth_i and
//   depth_valid_i; the block drives in_stall_o. Output channel: out_valid_o
//   with q_x_o, q_y_o, q_z_o and degenerate_o; the receiver drives out_stall_i.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (axis setups, translations, rotation rows); write only while idle.
//   Pipeline: from the accepting edge to out_valid_o a transaction passes
//   five front stages, two normalizers of 69 stages each (31 square root
//   stages and 31 divider stages, one bit per stage) and the output register.
//   Throughput: one transaction per cycle while not stalled; every stage holds at most one item.
//   Reset clears all valid bits and the configuration registers; the block
//   takes transactions right after reset.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall_o rises in the same cycle; nothing is dropped or repeated.
module detector_pixel_to_unit_q import dptu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] pixel_x_i,
  input  logic [23:0] pixel_y_i,
  input  logic signed [31:0] source_depth_i,
  input  logic        depth_valid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] q_x_o,
  output logic signed [31:0] q_y_o,
  output logic signed [31:0] q_z_o,
  output logic        degenerate_o
);

  localparam vec_t MID_ONE = vec_t'(1) <<< MID_FRAC;

  // configuration registers
  logic [63:0]        x_setup_q, y_setup_q, txy_q;
  logic [31:0]        tz_q;
  logic [3*COEF_W-1:0] rot_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_setup_q <= '0;
      y_setup_q <= '0;
      txy_q     <= '0;
      tz_q      <= '0;
      rot_q[0]  <= '0;
      rot_q[1]  <= '0;
      rot_q[2]  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_X_AXIS:   x_setup_q <= cfg_wdata_i;
        CFG_Y_AXIS:   y_setup_q <= cfg_wdata_i;
        CFG_TRANS_XY: txy_q     <= cfg_wdata_i;
        CFG_TRANS_Z:  tz_q      <= cfg_wdata_i[31:0];
        CFG_ROT_ROW0: rot_q[0]  <= cfg_wdata_i[3*COEF_W-1:0];
        CFG_ROT_ROW1: rot_q[1]  <= cfg_wdata_i[3*COEF_W-1:0];
        CFG_ROT_ROW2: rot_q[2]  <= cfg_wdata_i[3*COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a finished result is stalled
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // rounding, clamping and translation of one scaled axis offset
  function automatic logic signed [31:0] axis_um(input logic neg,
                                                 input logic [63:0] prod,
                                                 input logic signed [31:0] trans);
    logic [63:0]        rnd;
    logic [31:0]        r;
    logic signed [32:0] v;
    logic signed [33:0] sum;
    rnd = prod + 64'h8000;
    if (rnd[63:16] > 48'h8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = rnd[47:16];
    end
    if (neg) begin
      v = -$signed({1'b0, r});
    end else if (r[31]) begin
      v = 33'sh0_7FFF_FFFF;
    end else begin
      v = $signed({1'b0, r});
    end
    sum = 34'(v) + 34'(trans);
    if (sum > 34'sh0_7FFF_FFFF) begin
      axis_um = 32'sh7FFF_FFFF;
    end else if (sum < -34'sh0_8000_0000) begin
      axis_um = 32'sh8000_0000;
    end else begin
      axis_um = sum[31:0];
    end
  endfunction

  // stage a: centre offset magnitude and sign
  logic [32:0] dx_d, dy_d, ndx_d, ndy_d;
  logic        a_v_q, a_dv_q;
  logic [1:0]  a_neg_q;
  logic [31:0] a_mag_q [2];
  logic signed [31:0] a_depth_q;

  assign dx_d  = {9'd0, pixel_x_i} - {1'b0, x_setup_q[63:32]};
  assign dy_d  = {9'd0, pixel_y_i} - {1'b0, y_setup_q[63:32]};
  assign ndx_d = 33'd0 - dx_d;
  assign ndy_d = 33'd0 - dy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_neg_q    <= {dy_d[32], dx_d[32]};
      a_mag_q[0] <= dx_d[32] ? ndx_d[31:0] : dx_d[31:0];
      a_mag_q[1] <= dy_d[32] ? ndy_d[31:0] : dy_d[31:0];
      a_depth_q  <= source_depth_i;
      a_dv_q     <= depth_valid_i;
    end
  end

  // stage b: pitch products
  logic        b_v_q, b_dv_q;
  logic [1:0]  b_neg_q;
  logic [63:0] b_prod_q [2];
  logic signed [31:0] b_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_prod_q[0] <= 64'(a_mag_q[0]) * 64'(x_setup_q[31:0]);
      b_prod_q[1] <= 64'(a_mag_q[1]) * 64'(y_setup_q[31:0]);
      b_neg_q     <= a_neg_q;
      b_depth_q   <= a_depth_q;
      b_dv_q      <= a_dv_q;
    end
  end

  // stage c: detector plane point in micrometres
  logic               c_v_q, c_dv_q;
  logic signed [31:0] c_pt_q [3];
  logic signed [31:0] c_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_pt_q[0] <= axis_um(b_neg_q[0], b_prod_q[0], $signed(txy_q[31:0]));
      c_pt_q[1] <= axis_um(b_neg_q[1], b_prod_q[1], $signed(txy_q[63:32]));
      c_pt_q[2] <= $signed(tz_q);
      c_depth_q <= b_depth_q;
      c_dv_q    <= b_dv_q;
    end
  end

  // stage d: rotation products
  logic                      d_v_q, d_dv_q;
  logic signed [COEF_W+31:0] d_prod_q [3][3];
  logic signed [31:0]        d_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          d_prod_q[r][c] <= $signed(rot_q[r][COEF_W*c +: COEF_W]) * c_pt_q[c];
        end
      end
      d_depth_q <= c_depth_q;
      d_dv_q    <= c_dv_q;
    end
  end

  // stage e: row sums, depth correction on z
  vec_t      e_v_d [3];
  vec_t      e_v_q [3];
  unit_ctl_t e_ctl;
  logic      e_v_valid_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      e_v_d[r] = vec_t'(d_prod_q[r][0]) + vec_t'(d_prod_q[r][1])
               + vec_t'(d_prod_q[r][2]);
    end
    if (d_dv_q) begin
      e_v_d[2] = e_v_d[2] - (vec_t'(d_depth_q) <<< 19);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_valid_q <= 1'b0;
    end else if (en) begin
      e_v_valid_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_v_q <= e_v_d;
    end
  end

  assign e_ctl.valid = e_v_valid_q;
  assign e_ctl.ok    = 1'b1;

  // first normalization
  unit_ctl_t u1_ctl;
  res_t      u1_res [3];
  vec_t      u2_vec [3];

  dptu_unit u_norm1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .fb_i   (FB_W'(MID_FRAC)),
    .ctl_i  (e_ctl),
    .vec_i  (e_v_q),
    .ctl_o  (u1_ctl),
    .res_o  (u1_res)
  );

  // subtract the incident direction from z
  assign u2_vec[0] = vec_t'(u1_res[0]);
  assign u2_vec[1] = vec_t'(u1_res[1]);
  assign u2_vec[2] = vec_t'(u1_res[2]) - MID_ONE;

  // second normalization
  unit_ctl_t u2_ctl;
  res_t      u2_res [3];

  dptu_unit u_norm2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .fb_i   (FB_W'(OUT_FRAC_BITS)),
    .ctl_i  (u1_ctl),
    .vec_i  (u2_vec),
    .ctl_o  (u2_ctl),
    .res_o  (u2_res)
  );

  // output register
  res_t q_q [3];
  logic deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= u2_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_q[i] <= u2_ctl.ok ? u2_res[i] : '0;
      end
      deg_q <= !u2_ctl.ok;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign q_x_o        = q_q[0];
  assign q_y_o        = q_q[1];
  assign q_z_o        = q_q[2];
  assign degenerate_o = deg_q;

endmodule

>>> design/dptu_checker.sv
// port-level checks of the pixel to unit vector block, bound to the top level
// depends on dptu_pkg and the assertion macro header
`include "detector_pixel_to_unit_q_macros.svh"

module dptu_checker import dptu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic signed [31:0] q_x_o,
  input logic signed [31:0] q_y_o,
  input logic signed [31:0] q_z_o,
  input logic        degenerate_o
);

  // no result is shown while reset is held
  `DPTU_ASSERT_NR(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

  // the input side is held back only by a stalled output
  `DPTU_ASSERT(a_stall_cause, !out_stall_i |-> !in_stall_o, "input stalled without cause")

  // a degenerate transaction carries a zero vector
  `DPTU_ASSERT(a_deg_zero, (out_valid_o && degenerate_o) |-> (q_x_o == 0 && q_y_o == 0 && q_z_o == 0), "degenerate result not zero")

  // unit vector components stay within plus or minus one
  `DPTU_ASSERT(a_unit_range, out_valid_o |-> (q_x_o <= Q_LIMIT && q_x_o >= -Q_LIMIT && q_y_o <= Q_LIMIT && q_y_o >= -Q_LIMIT && q_z_o <= Q_LIMIT && q_z_o >= -Q_LIMIT), "component out of range")

endmodule

bind detector_pixel_to_unit_q dptu_checker u_dptu_checker (.*);
